// File: hdl/gce_pkg.sv
`default_nettype none

package gce_pkg;

    localparam int MAX_GLYPH_WIDTH_DEF  = 32;
    localparam int MAX_GLYPH_HEIGHT_DEF = 32;
    localparam int SPAN_FIFO_DEPTH_DEF  = 4;

    localparam int COLOR_W      = 16;
    localparam int SIZE_REG_W   = 6;
    localparam int SIZE_W       = 7;
    localparam int BYTE_W       = 8;
    localparam int PIX_PER_BYTE = 8;
    localparam int PIX_CNT_W    = 4;
    localparam int PIX_IDX_W    = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [SIZE_REG_W-1:0] GLYPH_WIDTH_RST  = SIZE_REG_W'(8);
    localparam logic [SIZE_REG_W-1:0] GLYPH_HEIGHT_RST = SIZE_REG_W'(16);
    localparam logic [COLOR_W-1:0]    FG_COLOR_RST     = 16'hFFFF;
    localparam logic [COLOR_W-1:0]    BG_COLOR_RST     = 16'h0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG_COLOR     = 2'd0,
        CFG_BG_COLOR     = 2'd1,
        CFG_GLYPH_WIDTH  = 2'd2,
        CFG_GLYPH_HEIGHT = 2'd3
    } cfg_index_t;

    // One classified font byte: its bits, how many pixels it yields, and
    // whether its last pixel closes a row and the glyph.
    typedef struct packed {
        logic [BYTE_W-1:0]    bits;
        logic [PIX_CNT_W-1:0] count;
        logic                 row_end;
        logic                 glyph_end;
    } span_t;

    // A zero size counts as one, and a size above the maximum saturates.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_REG_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] ext;
        ext = SIZE_W'(v);
        if (ext == '0) begin
            return SIZE_W'(1);
        end else if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

endpackage

`default_nettype wire

// File: hdl/glyph_color_expander.sv
// A byte is written into the span queue, then its first pixel into the output register.
// Throughput: one pixel per cycle while m_tready is high and the queue is not empty;
// a full byte yields 8 pixels and the last byte of a row up to 8, on the single output.
// Input transactions are taken every cycle while the span queue has room.
// Reset (synchronous, aresetn low) clears the row and column counters, the queue and the
// output valid flag, and loads fg_color 0xFFFF, bg_color 0x0000, width 8 and height 16.
`default_nettype none

module glyph_color_expander
    import gce_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH  = MAX_GLYPH_WIDTH_DEF,
    parameter int MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF,
    parameter int SPAN_FIFO_DEPTH  = SPAN_FIFO_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,  // [7:0] font_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [COLOR_W-1:0]         m_tdata,  // [15:0] pixel_color
    output logic                       m_tlast,  // row_end
    output logic                       m_tuser   // [0] glyph_end
);

    logic [COLOR_W-1:0]    fg_color_reg, bg_color_reg;
    logic [SIZE_REG_W-1:0] glyph_width_reg, glyph_height_reg;
    logic                  push, pop, fifo_full, fifo_empty;
    span_t                 push_data, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_color_reg     <= FG_COLOR_RST;
            bg_color_reg     <= BG_COLOR_RST;
            glyph_width_reg  <= GLYPH_WIDTH_RST;
            glyph_height_reg <= GLYPH_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FG_COLOR:     fg_color_reg     <= cfg_wdata[COLOR_W-1:0];
                CFG_BG_COLOR:     bg_color_reg     <= cfg_wdata[COLOR_W-1:0];
                CFG_GLYPH_WIDTH:  glyph_width_reg  <= cfg_wdata[SIZE_REG_W-1:0];
                CFG_GLYPH_HEIGHT: glyph_height_reg <= cfg_wdata[SIZE_REG_W-1:0];
                default: ;
            endcase
        end
    end

    gce_front #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .glyph_width  (glyph_width_reg),
        .glyph_height (glyph_height_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_data    (push_data)
    );

    gce_fifo #(
        .DEPTH (SPAN_FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    gce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fg_color   (fg_color_reg),
        .bg_color   (bg_color_reg),
        .fifo_empty (fifo_empty),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/gce_front.sv
`default_nettype none

module gce_front
    import gce_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH  = MAX_GLYPH_WIDTH_DEF,
    parameter int MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [SIZE_REG_W-1:0] glyph_width,
    input  wire logic [SIZE_REG_W-1:0] glyph_height,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,
    input  wire logic                  fifo_full,
    output logic                       push,
    output span_t                      push_data
);

    localparam int COL_W = $clog2(MAX_GLYPH_WIDTH);
    localparam int ROW_W = $clog2(MAX_GLYPH_HEIGHT);

    logic [COL_W-1:0]     col_reg, col_next, col_eff;
    logic [ROW_W-1:0]     row_reg, row_next, row_eff;
    logic [SIZE_W-1:0]    width_c, height_c, remain, row_inc;
    logic [PIX_CNT_W-1:0] count;
    logic                 row_end, glyph_end;

    always_comb begin
        width_c  = clamp_size(glyph_width, SIZE_W'(MAX_GLYPH_WIDTH));
        height_c = clamp_size(glyph_height, SIZE_W'(MAX_GLYPH_HEIGHT));

        // Counters left beyond a size that was lowered restart at zero.
        col_eff = (SIZE_W'(col_reg) >= width_c) ? '0 : col_reg;
        row_eff = (SIZE_W'(row_reg) >= height_c) ? '0 : row_reg;

        remain    = width_c - SIZE_W'(col_eff);
        row_end   = (remain <= SIZE_W'(PIX_PER_BYTE));
        count     = row_end ? PIX_CNT_W'(remain) : PIX_CNT_W'(PIX_PER_BYTE);
        row_inc   = SIZE_W'(row_eff) + SIZE_W'(1);
        glyph_end = row_end && (row_inc >= height_c);

        s_tready  = !fifo_full;
        push      = s_tvalid && !fifo_full;

        push_data.bits      = s_tdata;
        push_data.count     = count;
        push_data.row_end   = row_end;
        push_data.glyph_end = glyph_end;

        col_next = col_reg;
        row_next = row_reg;
        if (push) begin
            if (row_end) begin
                col_next = '0;
                row_next = glyph_end ? '0 : ROW_W'(row_inc);
            end else begin
                col_next = COL_W'(SIZE_W'(col_eff) + SIZE_W'(count));
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/gce_fifo.sv
`default_nettype none

module gce_fifo
    import gce_pkg::*;
#(
    parameter int DEPTH = SPAN_FIFO_DEPTH_DEF
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire span_t push_data,
    input  wire logic  pop,
    output span_t      head,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    span_t            entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("span queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("span queue read while empty");

endmodule

`default_nettype wire

// File: hdl/gce_back.sv
`default_nettype none

module gce_back
    import gce_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [COLOR_W-1:0] fg_color,
    input  wire logic [COLOR_W-1:0] bg_color,
    input  wire logic               fifo_empty,
    input  wire span_t              head,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [COLOR_W-1:0]      m_tdata,
    output logic                    m_tlast,
    output logic                    m_tuser
);

    logic [PIX_IDX_W-1:0] pix_idx_reg, pix_idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [COLOR_W-1:0]   pixel_reg, pixel_next;
    logic                 row_end_reg, row_end_next;
    logic                 glyph_end_reg, glyph_end_next;
    logic                 load, last_pix, bit_set;

    always_comb begin
        load     = !fifo_empty && (!m_tvalid_reg || m_tready);
        last_pix = (PIX_CNT_W'(pix_idx_reg) + PIX_CNT_W'(1)) == head.count;
        bit_set  = head.bits[PIX_IDX_W'(PIX_PER_BYTE - 1) - pix_idx_reg];
        pop      = load && last_pix;

        pix_idx_next   = pix_idx_reg;
        m_tvalid_next  = m_tvalid_reg;
        pixel_next     = pixel_reg;
        row_end_next   = row_end_reg;
        glyph_end_next = glyph_end_reg;

        if (load) begin
            m_tvalid_next  = 1'b1;
            pixel_next     = bit_set ? fg_color : bg_color;
            // Only the last pixel of a byte can close a row.
            row_end_next   = last_pix && head.row_end;
            glyph_end_next = last_pix && head.glyph_end;
            pix_idx_next   = last_pix ? '0 : pix_idx_reg + 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pix_idx_reg  <= pix_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pixel_reg     <= pixel_next;
        row_end_reg   <= row_end_next;
        glyph_end_reg <= glyph_end_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pixel_reg;
    assign m_tlast  = row_end_reg;
    assign m_tuser  = glyph_end_reg;

    a_glyph_end_on_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("glyph end flagged away from a row end");

    a_index_in_span: assert property (@(posedge aclk) disable iff (!aresetn)
        !fifo_empty |-> (PIX_CNT_W'(pix_idx_reg) < head.count))
        else $error("pixel index beyond the byte's pixel count");

endmodule

`default_nettype wire
